// File: rtl/packed_nibble_framebuffer_draw_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the framebuffer draw engine
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PACKED_NIBBLE_FRAMEBUFFER_DRAW_DEFINES_SVH
`define PACKED_NIBBLE_FRAMEBUFFER_DRAW_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PNFB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pnfb assertion failed");

// Next-cycle implication.
`define PNFB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pnfb assertion failed");

`else

`define PNFB_ASSERT_IMP(label, clk, rst, ante, cons)
`define PNFB_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/pnfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnfb_pkg
// Screen geometry, derived widths, command codes and shared types of the
// framebuffer draw engine.
// ----------------------------------------------------------------------------
package pnfb_pkg;

   // Screen geometry. Four 4-bit pixels share one 16-bit word.
   localparam int SCREEN_WIDTH  = 160;
   localparam int SCREEN_HEIGHT = 120;
   localparam int WORDS_PER_ROW = 40;
   localparam int BUF_WORDS     = WORDS_PER_ROW * SCREEN_HEIGHT;

   // Word index: covers a buffer plus the widest possible row offset.
   localparam int IDX_W  = $clog2(BUF_WORDS + 257);
   // Memory holds both buffers back to back.
   localparam int MEM_AW = $clog2(2 * BUF_WORDS);
   // Row and column counts of a fill or clear sweep.
   localparam int ROW_W   = $clog2(SCREEN_HEIGHT + 1);
   localparam int COL_MAX = (WORDS_PER_ROW > SCREEN_WIDTH / 4) ?
                            WORDS_PER_ROW : SCREEN_WIDTH / 4;
   localparam int COL_W   = $clog2(COL_MAX + 1);

   // Command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Command codes on the request channel.
   localparam logic [2:0] KIND_CLEAR   = 3'd0;
   localparam logic [2:0] KIND_PIXEL   = 3'd1;
   localparam logic [2:0] KIND_FILL    = 3'd2;
   localparam logic [2:0] KIND_SELECT  = 3'd3;
   localparam logic [2:0] KIND_SWAP    = 3'd4;
   localparam logic [2:0] KIND_PRESENT = 3'd5;
   localparam logic [2:0] KIND_READ    = 3'd6;

   // Classified operation as handed to the back part.
   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_PIXEL,
      OP_FILL,
      OP_SELECT,
      OP_SWAP,
      OP_PRESENT,
      OP_READ,
      OP_REJECT
   } pnfb_op_type;

   // Back part sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_READ,
      ST_DONE
   } pnfb_state_type;

   // One classified command.
   typedef struct packed {
      pnfb_op_type        op;
      logic [IDX_W-1:0]   word_idx;
      logic [1:0]         nib;
      logic [3:0]         color;
      logic               sel;
      logic [ROW_W-1:0]   rows;
      logic [COL_W-1:0]   cols;
   } pnfb_cmd_type;

   // Queue occupancy flags.
   typedef struct packed {
      logic full;
      logic empty;
   } pnfb_q_status_type;

endpackage
`default_nettype wire

// File: rtl/pnfb_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnfb channels
// Valid/ready channels for drawing requests and their responses.
// ----------------------------------------------------------------------------

// Request channel: one drawing command per word.
interface pnfb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [8:0] x_pos;
   logic [8:0] y_pos;
   logic [8:0] rect_width;
   logic [8:0] rect_height;
   logic [3:0] color;
   logic       buffer_select;
   logic [12:0] word_addr;

   modport source (output valid, kind, x_pos, y_pos, rect_width, rect_height,
                   color, buffer_select, word_addr, input ready);
   modport sink   (input valid, kind, x_pos, y_pos, rect_width, rect_height,
                   color, buffer_select, word_addr, output ready);
endinterface

// Response channel: one result word per command.
interface pnfb_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [15:0] read_data;
   logic        draw_buffer;
   logic        display_buffer;

   modport source (output valid, status, read_data, draw_buffer, display_buffer,
                   input ready);
   modport sink   (input valid, status, read_data, draw_buffer, display_buffer,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/pnfb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnfb_front
// Accepts requests, checks their ranges and turns each into a classified
// command with its start word and sweep size.
// ----------------------------------------------------------------------------
module pnfb_front (
   pnfb_req_if.sink                 req_if,
   input  pnfb_pkg::pnfb_q_status_type q_status,
   output logic                     push,
   output pnfb_pkg::pnfb_cmd_type   push_cmd
);
   import pnfb_pkg::*;

   logic [9:0]       x_right;
   logic [9:0]       y_bottom;
   logic             on_screen;
   logic             fill_ok;
   logic [IDX_W-1:0] pixel_idx;

   // Take a word whenever the queue has room.
   assign req_if.ready = !q_status.full;
   assign push         = req_if.valid && req_if.ready;

   // Range checks and the start word of a pixel or rectangle.
   assign x_right   = {1'b0, req_if.x_pos} + {1'b0, req_if.rect_width};
   assign y_bottom  = {1'b0, req_if.y_pos} + {1'b0, req_if.rect_height};
   assign on_screen = (req_if.x_pos < SCREEN_WIDTH) && (req_if.y_pos < SCREEN_HEIGHT);
   assign fill_ok   = on_screen && (req_if.rect_width != 9'd0) &&
                      (req_if.rect_height != 9'd0) && (req_if.x_pos[1:0] == 2'd0) &&
                      (req_if.rect_width[1:0] == 2'd0) && (x_right <= SCREEN_WIDTH) &&
                      (y_bottom <= SCREEN_HEIGHT);
   assign pixel_idx = IDX_W'(IDX_W'(req_if.y_pos) * IDX_W'(WORDS_PER_ROW)) +
                      IDX_W'(req_if.x_pos[8:2]);

   // Classify the word into a command for the back part.
   always_comb begin
      push_cmd       = '0;
      push_cmd.op    = OP_REJECT;
      push_cmd.nib   = req_if.x_pos[1:0];
      push_cmd.color = req_if.color;
      push_cmd.sel   = req_if.buffer_select;
      case (req_if.kind)
         KIND_CLEAR: begin
            push_cmd.op   = OP_CLEAR;
            push_cmd.rows = ROW_W'(SCREEN_HEIGHT);
            push_cmd.cols = COL_W'(WORDS_PER_ROW);
         end
         KIND_PIXEL: begin
            if (on_screen) begin
               push_cmd.op       = OP_PIXEL;
               push_cmd.word_idx = pixel_idx;
            end
         end
         KIND_FILL: begin
            if (fill_ok) begin
               push_cmd.op       = OP_FILL;
               push_cmd.word_idx = pixel_idx;
               push_cmd.rows     = ROW_W'(req_if.rect_height);
               push_cmd.cols     = COL_W'(req_if.rect_width[8:2]);
            end
         end
         KIND_SELECT:  push_cmd.op = OP_SELECT;
         KIND_SWAP:    push_cmd.op = OP_SWAP;
         KIND_PRESENT: push_cmd.op = OP_PRESENT;
         KIND_READ: begin
            if (req_if.word_addr < BUF_WORDS) begin
               push_cmd.op       = OP_READ;
               push_cmd.word_idx = IDX_W'(req_if.word_addr);
            end
         end
         default: push_cmd.op = OP_REJECT;
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/pnfb_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pnfb_queue
// Short first-in first-out queue of classified commands between the front
// and back parts.
// ----------------------------------------------------------------------------
module pnfb_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  pnfb_pkg::pnfb_cmd_type      push_cmd,
   input  logic                        pop,
   output pnfb_pkg::pnfb_cmd_type      head_cmd,
   output pnfb_pkg::pnfb_q_status_type q_status
);
   import pnfb_pkg::*;

   pnfb_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

endmodule
`default_nettype wire

// File: rtl/pnfb_back.sv
`default_nettype none
`include "packed_nibble_framebuffer_draw_defines.svh"
// ----------------------------------------------------------------------------
// pnfb_back
// Executes classified commands on the two pixel buffers and returns one
// response word per command through an output register.
// ----------------------------------------------------------------------------
module pnfb_back (
   input  logic                        clock,
   input  logic                        reset,
   input  pnfb_pkg::pnfb_q_status_type q_status,
   input  pnfb_pkg::pnfb_cmd_type      head_cmd,
   output logic                        pop,
   pnfb_rsp_if.source                  rsp_if
);
   import pnfb_pkg::*;

   // Both buffers, buffer one placed after buffer zero.
   logic [15:0]       mem [2 * BUF_WORDS];
   logic [15:0]       mem_rd_ff;

   pnfb_state_type    state_ff, state_in;
   pnfb_cmd_type      cmd_ff;
   logic [IDX_W-1:0]  row_base_ff, row_base_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              draw_ff, draw_in;
   logic              disp_ff, disp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              status_ff;
   logic [15:0]       read_data_ff;
   logic              draw_out_ff;
   logic              disp_out_ff;

   logic [IDX_W-1:0]  fill_ptr;
   logic              col_last;
   logic              row_last;
   logic              fill_last;
   logic              pix_in_range;
   logic              fill_in_range;
   logic              rsp_free;
   logic              rsp_load;
   logic              fill_step;
   logic              mem_we;
   logic [MEM_AW-1:0] mem_wa;
   logic [15:0]       mem_wd;
   logic              mem_re;
   logic [MEM_AW-1:0] mem_ra;
   logic [15:0]       merged;

   // Sweep position and range checks.
   assign fill_ptr      = row_base_ff + IDX_W'(col_ff);
   assign col_last      = (col_ff + COL_W'(1)) == cmd_ff.cols;
   assign row_last      = (row_ff + ROW_W'(1)) == cmd_ff.rows;
   assign fill_last     = col_last && row_last;
   assign fill_in_range = fill_ptr < BUF_WORDS;
   assign pix_in_range  = cmd_ff.word_idx < BUF_WORDS;
   assign rsp_free      = !rsp_valid_ff || rsp_if.ready;

   // Replace one nibble of the word just read.
   always_comb begin
      merged = mem_rd_ff;
      case (cmd_ff.nib)
         2'd0:    merged[15:12] = cmd_ff.color;
         2'd1:    merged[11:8]  = cmd_ff.color;
         2'd2:    merged[7:4]   = cmd_ff.color;
         default: merged[3:0]   = cmd_ff.color;
      endcase
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               case (head_cmd.op)
                  OP_CLEAR, OP_FILL: state_in = ST_FILL;
                  OP_PIXEL:          state_in = ST_PIX_RD;
                  OP_READ:           state_in = ST_READ;
                  default:           state_in = ST_DONE;
               endcase
            end
         end
         ST_FILL:   state_in = fill_last ? ST_DONE : ST_FILL;
         ST_PIX_RD: state_in = pix_in_range ? ST_PIX_WR : ST_DONE;
         ST_PIX_WR: state_in = ST_DONE;
         ST_READ:   state_in = ST_DONE;
         ST_DONE:   state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: queue pop, memory strobes and response load.
   always_comb begin
      pop       = 1'b0;
      fill_step = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = draw_ff ? MEM_AW'(BUF_WORDS) + MEM_AW'(fill_ptr) : MEM_AW'(fill_ptr);
      mem_wd    = {4{cmd_ff.color}};
      mem_re    = 1'b0;
      mem_ra    = draw_ff ? MEM_AW'(BUF_WORDS) + MEM_AW'(cmd_ff.word_idx) :
                            MEM_AW'(cmd_ff.word_idx);
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: pop = !q_status.empty;
         ST_FILL: begin
            fill_step = 1'b1;
            mem_we    = fill_in_range;
         end
         ST_PIX_RD: mem_re = pix_in_range;
         ST_PIX_WR: begin
            mem_we = 1'b1;
            mem_wa = mem_ra;
            mem_wd = merged;
         end
         ST_READ: begin
            mem_re = 1'b1;
            mem_ra = cmd_ff.sel ? MEM_AW'(BUF_WORDS) + MEM_AW'(cmd_ff.word_idx) :
                                  MEM_AW'(cmd_ff.word_idx);
         end
         ST_DONE: rsp_load = rsp_free;
         default: pop = 1'b0;
      endcase
   end

   // Buffer indexes after the command, and the sweep counters.
   always_comb begin
      draw_in     = draw_ff;
      disp_in     = disp_ff;
      row_base_in = row_base_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (rsp_load) begin
         case (cmd_ff.op)
            OP_SELECT:  draw_in = cmd_ff.sel;
            OP_SWAP:    draw_in = !draw_ff;
            OP_PRESENT: disp_in = draw_ff;
            default:    draw_in = draw_ff;
         endcase
      end
      if (pop) begin
         row_base_in = head_cmd.word_idx;
         col_in      = '0;
         row_in      = '0;
      end else if (fill_step) begin
         if (col_last) begin
            col_in      = '0;
            row_base_in = row_base_ff + IDX_W'(WORDS_PER_ROW);
            row_in      = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         draw_ff      <= 1'b0;
         disp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         draw_ff      <= draw_in;
         disp_ff      <= disp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command and sweep registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head_cmd;
      end
      row_base_ff <= row_base_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         status_ff    <= (cmd_ff.op == OP_REJECT);
         read_data_ff <= (cmd_ff.op == OP_READ) ? mem_rd_ff : 16'd0;
         draw_out_ff  <= draw_in;
         disp_out_ff  <= disp_in;
      end
   end

   // Pixel memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_ra];
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.read_data      = read_data_ff;
   assign rsp_if.draw_buffer    = draw_out_ff;
   assign rsp_if.display_buffer = disp_out_ff;

   // Checks on the sequencer.
   `PNFB_ASSERT_IMP(a_pop_needs_entry, clock, reset, pop, !q_status.empty)
   `PNFB_ASSERT_IMP(a_no_read_on_write, clock, reset, mem_we, !mem_re)
   `PNFB_ASSERT_IMP(a_load_when_free, clock, reset, rsp_load, !rsp_valid_ff || rsp_if.ready)
   `PNFB_ASSERT_IMP(a_write_in_memory, clock, reset, mem_we, mem_wa < 2 * BUF_WORDS)
   `PNFB_ASSERT_NXT(a_swap_toggles, clock, reset, rsp_load && (cmd_ff.op == OP_SWAP), draw_ff != $past(draw_ff))

endmodule
`default_nettype wire

// File: rtl/packed_nibble_framebuffer_draw.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packed_nibble_framebuffer_draw
// Drawing engine over two buffers of 4-bit pixels, four pixels to a 16-bit
// word with the leftmost pixel in the top nibble. Every request word gives
// exactly one response word. The front part checks and classifies requests
// and queues up to two commands, so requests keep flowing while the back part
// works on the pixel memory. A put pixel command reads, merges and writes one
// word; clear and fill rect write one word per cycle. The back part handles
// one command at a time and takes the next from the queue only after the
// response of the last one is loaded.
// ----------------------------------------------------------------------------
module packed_nibble_framebuffer_draw (
   input  logic       clock,
   input  logic       reset,
   pnfb_req_if.sink   req_if,
   pnfb_rsp_if.source rsp_if
);
   import pnfb_pkg::*;

   logic              push;
   logic              pop;
   pnfb_cmd_type      push_cmd;
   pnfb_cmd_type      head_cmd;
   pnfb_q_status_type q_status;

   // Request checking and classification.
   pnfb_front u_front (
      .req_if   (req_if),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // Command queue between the two parts.
   pnfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   // Execution on the pixel memory and response output.
   pnfb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head_cmd (head_cmd),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule
`default_nettype wire
